### rtl/core/integer_to_ascii_converter_macros.svh
// assertion helpers for the integer to ascii converter
// all checks are clocked on clk and held off while arst_n is low
`ifndef INTEGER_TO_ASCII_CONVERTER_MACROS_SVH
`define INTEGER_TO_ASCII_CONVERTER_MACROS_SVH

`ifndef SYNTHESIS
`define I2A_ASSERT_IMP(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);
`define I2A_ASSERT_NXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);
`else
`define I2A_ASSERT_IMP(name, pre, post, msg)
`define I2A_ASSERT_NXT(name, pre, post, msg)
`endif

`endif

### rtl/core/i2a_pkg.sv
`default_nettype none

package i2a_pkg;

	localparam int VALUE_W       = 64;
	localparam int DIGIT_W       = 4;
	localparam int FUNC_W        = 2;
	localparam int CHAR_W        = 8;
	// input bits folded into the bcd register per conversion cycle
	localparam int STEP_BITS     = 4;
	localparam int CONV_STEPS    = VALUE_W / STEP_BITS;
	localparam int HEX_DIGITS    = VALUE_W / DIGIT_W;
	localparam int MAX_CHARS_DEF = 20;

	typedef logic [FUNC_W-1:0] func_t;
	typedef logic [CHAR_W-1:0] char_t;
	typedef logic [DIGIT_W-1:0] digit_t;

	localparam func_t FN_SDEC = 2'd0;
	localparam func_t FN_UDEC = 2'd1;
	localparam func_t FN_HEX  = 2'd2;
	localparam func_t FN_PTR  = 2'd3;

	localparam char_t CH_ZERO  = 8'h30;
	localparam char_t CH_X     = 8'h78;
	localparam char_t CH_MINUS = 8'h2d;
	localparam char_t CH_A     = 8'h61;

	function automatic char_t hex_char(input digit_t d);
		char_t c;
		if (d < digit_t'(10))
			c = CH_ZERO + {4'b0000, d};
		else
			c = CH_A + {4'b0000, d} - 8'd10;
		return c;
	endfunction

endpackage

`default_nettype wire

### rtl/core/i2a_dabble.sv
`default_nettype none

// shift-add-3 unit: moves STEP_BITS binary bits into a packed bcd register
module i2a_dabble #(
	parameter int NUM_DIGITS = i2a_pkg::MAX_CHARS_DEF
) (
	input  wire logic [NUM_DIGITS*i2a_pkg::DIGIT_W-1:0] digits,
	input  wire logic [i2a_pkg::VALUE_W-1:0]            bits,
	output logic      [NUM_DIGITS*i2a_pkg::DIGIT_W-1:0] next_digits,
	output logic      [i2a_pkg::VALUE_W-1:0]            next_bits
);
	import i2a_pkg::*;

	localparam int DIG_W = NUM_DIGITS * DIGIT_W;

	logic [DIG_W-1:0]   d;
	logic [VALUE_W-1:0] b;

	always_comb begin
		d = digits;
		b = bits;
		for (int s = 0; s < STEP_BITS; s++) begin
			for (int k = 0; k < NUM_DIGITS; k++) begin
				if (d[k*DIGIT_W +: DIGIT_W] >= digit_t'(5))
					d[k*DIGIT_W +: DIGIT_W] = d[k*DIGIT_W +: DIGIT_W] + digit_t'(3);
			end
			{d, b} = {d[DIG_W-2:0], b, 1'b0};
		end
		next_digits = d;
		next_bits   = b;
	end

endmodule

`default_nettype wire

### rtl/core/integer_to_ascii_converter.sv
`default_nettype none
`include "integer_to_ascii_converter_macros.svh"

// Prints a 64-bit value as ascii text, one character per output beat, most significant
// character first, with m_tlast on the final character. s_tuser selects the format:
// signed decimal, unsigned decimal, lowercase hex (no leading zeros, zero prints "0") or
// pointer ("0x" and 16 zero-padded hex digits). One value is handled at a time and
// s_tready is low from acceptance until its last character has been loaded into the
// output register. Decimal values first run through a single shift-add-3 unit
// that folds four binary bits per cycle into a MAX_CHARS-digit bcd register; the digit
// register is then scanned one digit per cycle, leading zeros skipped, while the output
// register can take each printed digit, preceded by a minus sign when the value is
// negative. A due character waits while the output register is full and m_tready is
// low; skipped leading zeros never wait.
module integer_to_ascii_converter #(
	parameter int MAX_CHARS = i2a_pkg::MAX_CHARS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [i2a_pkg::VALUE_W-1:0]   s_tdata,  // [63:0] value
	input  wire logic [i2a_pkg::FUNC_W-1:0]    s_tuser,  // [1:0] func
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic      [i2a_pkg::CHAR_W-1:0]    m_tdata,  // [7:0] char_code
	output logic                               m_tlast
);
	import i2a_pkg::*;

	localparam int DIG_W = MAX_CHARS * DIGIT_W;
	localparam int PAD_W = DIG_W - VALUE_W;
	localparam int REM_W = $clog2(MAX_CHARS + 1);
	localparam int CNT_W = $clog2(CONV_STEPS);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_CONV   = 2'd1;
	localparam logic [1:0] ST_PREFIX = 2'd2;
	localparam logic [1:0] ST_EMIT   = 2'd3;

	logic [1:0]         state_q;
	logic [REM_W-1:0]   rem_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               pfx_q;
	logic               started_q;
	func_t              func_q;
	logic               neg_q;
	logic [DIG_W-1:0]   dig_q;
	logic [VALUE_W-1:0] bin_q;
	logic               out_valid_q;
	char_t              out_char_q;
	logic               out_last_q;

	logic [DIG_W-1:0]   next_dig;
	logic [VALUE_W-1:0] next_bin;
	logic               accept;
	logic               is_dec;
	logic               neg_in;
	logic [VALUE_W-1:0] mag_in;
	logic               slot_free;
	digit_t             top_dig;
	logic               emit_now;
	logic               advance;
	logic               last_dig;
	logic               out_load;
	char_t              out_char_d;
	logic               out_last_d;

	i2a_dabble #(
		.NUM_DIGITS(MAX_CHARS)
	) u_dabble (
		.digits     (dig_q),
		.bits       (bin_q),
		.next_digits(next_dig),
		.next_bits  (next_bin)
	);

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign is_dec    = (s_tuser == FN_SDEC) || (s_tuser == FN_UDEC);
	assign neg_in    = (s_tuser == FN_SDEC) && s_tdata[VALUE_W-1];
	assign mag_in    = neg_in ? (~s_tdata + VALUE_W'(1)) : s_tdata;
	assign slot_free = !out_valid_q || m_tready;
	assign top_dig   = dig_q[DIG_W-1 -: DIGIT_W];
	assign last_dig  = (rem_q == REM_W'(1));
	// leading zeros are dropped, but the final digit always prints
	assign emit_now  = started_q || (top_dig != '0) || last_dig;
	assign advance   = !emit_now || slot_free;

	always_comb begin
		out_load   = 1'b0;
		out_char_d = CH_ZERO;
		out_last_d = 1'b0;
		unique case (state_q)
			ST_PREFIX: begin
				out_load = slot_free;
				if (func_q == FN_PTR)
					out_char_d = pfx_q ? CH_X : CH_ZERO;
				else
					out_char_d = CH_MINUS;
			end
			ST_EMIT: begin
				out_load   = slot_free && emit_now;
				out_char_d = hex_char(top_dig);
				out_last_d = last_dig;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rem_q       <= '0;
			cnt_q       <= '0;
			pfx_q       <= 1'b0;
			started_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cnt_q <= '0;
						pfx_q <= 1'b0;
						if (is_dec) begin
							rem_q     <= REM_W'(MAX_CHARS);
							started_q <= 1'b0;
							state_q   <= ST_CONV;
						end else begin
							rem_q     <= REM_W'(HEX_DIGITS);
							started_q <= (s_tuser == FN_PTR);
							state_q   <= (s_tuser == FN_PTR) ? ST_PREFIX : ST_EMIT;
						end
					end
				end
				ST_CONV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(CONV_STEPS - 1))
						state_q <= neg_q ? ST_PREFIX : ST_EMIT;
				end
				ST_PREFIX: begin
					if (slot_free) begin
						if (func_q == FN_PTR && !pfx_q)
							pfx_q <= 1'b1;
						else
							state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (advance) begin
						rem_q <= rem_q - REM_W'(1);
						if (emit_now)
							started_q <= 1'b1;
						if (last_dig)
							state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_char_q <= out_char_d;
			out_last_q <= out_last_d;
		end
		if (accept) begin
			func_q <= s_tuser;
			neg_q  <= neg_in;
			bin_q  <= mag_in;
			// hex digits sit left-aligned so the scan starts at the top nibble
			dig_q  <= is_dec ? '0 : {s_tdata, {PAD_W{1'b0}}};
		end else if (state_q == ST_CONV) begin
			dig_q <= next_dig;
			bin_q <= next_bin;
		end else if (state_q == ST_EMIT && advance) begin
			dig_q <= {dig_q[DIG_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_char_q;
	assign m_tlast  = out_last_q;

	`I2A_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready after accept")
	`I2A_ASSERT_IMP(a_emit_has_digits, state_q == ST_EMIT, rem_q != '0, "digit scan overran")
	`I2A_ASSERT_NXT(a_last_ends_item, out_load && out_last_d, state_q == ST_IDLE, "last beat not final")
	`I2A_ASSERT_IMP(a_ptr_keeps_zeros, state_q == ST_EMIT && func_q == FN_PTR, started_q,
		"pointer digits suppressed")

endmodule

`default_nettype wire

### tb/sv/integer_to_ascii_converter_tb.sv
`default_nettype none

module integer_to_ascii_converter_tb;
	import i2a_pkg::*;

	localparam int STALL_LIMIT = 3000;
	localparam int RANDOM_ITEMS = 340;
	localparam int TAIL_CYCLES = 80;
	localparam int HOLD_CYCLES = 400;
	// glyph table, character 0 sits in the top byte
	localparam logic [8*16-1:0] GLYPHS = "0123456789abcdef";

	typedef struct {
		logic [VALUE_W-1:0] value;
		func_t func;
		int gap;
	} text_req_t;

	typedef struct packed {
		char_t code;
		logic last;
	} char_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [VALUE_W-1:0] s_tdata = '0;
	func_t s_tuser = FN_SDEC;
	logic m_tvalid;
	logic m_tready = 1'b0;
	char_t m_tdata;
	logic m_tlast;

	text_req_t requests[$];
	char_beat_t expected_chars[$];
	int errors = 0;
	int chars_seen = 0;
	int idle_cycles = 0;
	logic in_fire = 1'b0;
	logic out_fire = 1'b0;
	bit tx_calm = 1'b0;

	integer_to_ascii_converter dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic char_t glyph(input int d);
		return GLYPHS[8*(15-d) +: 8];
	endfunction

	// expected text of one value, pushed as beats onto the expectation queue
	function automatic void render_text(input logic [VALUE_W-1:0] v, input func_t f);
		char_t txt[$];
		logic [VALUE_W-1:0] mag;
		logic [VALUE_W-1:0] radix;
		bit neg;
		char_beat_t b;
		if (f == FN_PTR) begin
			txt.push_back(CH_ZERO);
			txt.push_back(CH_X);
			for (int i = 15; i >= 0; i--)
				txt.push_back(glyph(int'(v[4*i +: 4])));
		end else begin
			radix = (f == FN_HEX) ? 64'd16 : 64'd10;
			neg = (f == FN_SDEC) && v[VALUE_W-1];
			mag = neg ? (64'd0 - v) : v;
			do begin
				txt.push_front(glyph(int'(mag % radix)));
				mag = mag / radix;
			end while (mag != 0);
			if (neg)
				txt.push_front(CH_MINUS);
		end
		foreach (txt[k]) begin
			b.code = txt[k];
			b.last = (k == txt.size() - 1);
			expected_chars.push_back(b);
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] want,
			input logic [63:0] got);
		$display("mismatch on %s at beat %0d: expected %0h got %0h", what, chars_seen, want, got);
		errors++;
	endtask

	function automatic logic [VALUE_W-1:0] pick_value();
		logic [VALUE_W-1:0] v;
		logic [VALUE_W-1:0] p;
		int k;
		v = {$urandom(), $urandom()};
		case ($urandom_range(0, 5))
			0: ;
			1: v = 64'($urandom_range(0, 20));
			2: v = v >> $urandom_range(0, 63);
			// negative values, the magnitude shifted right by a random amount
			3: v = 64'd0 - (v >> $urandom_range(1, 63));
			4: begin
				p = 64'd1;
				k = $urandom_range(0, 19);
				repeat (k) p = p * 64'd10;
				v = p + 64'($urandom_range(0, 2)) - 64'd1;
			end
			default: v = 64'd1 << $urandom_range(0, 63);
		endcase
		return v;
	endfunction

	function automatic int pick_gap();
		return tx_calm ? 0 : $urandom_range(0, 14);
	endfunction

	task automatic queue_text(input logic [VALUE_W-1:0] v, input func_t f);
		text_req_t r;
		r.value = v;
		r.func = f;
		r.gap = pick_gap();
		requests.push_back(r);
	endtask

	// sender
	always @(negedge clk) begin
		static int tx_wait = 0;
		text_req_t r;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || in_fire) begin
			if (tx_wait > 0) begin
				tx_wait--;
				s_tvalid <= 1'b0;
			end else if (requests.size() > 0) begin
				r = requests.pop_front();
				s_tdata <= r.value;
				s_tuser <= r.func;
				s_tvalid <= 1'b1;
				tx_wait = (requests.size() > 0) ? requests[0].gap : 0;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver, with a long hold-off at a couple of points to back up the input
	always @(negedge clk) begin
		static int rx_wait = 0;
		static int hold_left = 0;
		static int next_hold_at = 300;
		static bit rx_calm = 1'b0;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (next_hold_at != 0 && chars_seen >= next_hold_at) begin
				hold_left = HOLD_CYCLES;
				next_hold_at = (next_hold_at == 300) ? 2000 : 0;
			end
			if (out_fire) begin
				if (chars_seen % 50 == 0)
					rx_calm = ($urandom_range(0, 3) == 0);
				rx_wait = rx_calm ? 0 : $urandom_range(0, 14);
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (rx_wait > 0) begin
				rx_wait--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		char_beat_t want;
		if (!arst_n) begin
			in_fire <= 1'b0;
			out_fire <= 1'b0;
		end else begin
			in_fire <= s_tvalid && s_tready;
			out_fire <= m_tvalid && m_tready;
			if (s_tvalid && s_tready)
				render_text(s_tdata, s_tuser);
			if (m_tvalid && m_tready) begin
				chars_seen++;
				if (expected_chars.size() == 0) begin
					report_mismatch("unexpected beat", 64'd0, 64'({m_tlast, m_tdata}));
				end else begin
					want = expected_chars.pop_front();
					if (m_tdata !== want.code)
						report_mismatch("char_code", 64'(want.code), 64'(m_tdata));
					if (m_tlast !== want.last)
						report_mismatch("last", 64'(want.last), 64'(m_tlast));
				end
			end
		end
	end

	// watchdog on cycles without any beat on either side
	initial begin
		@(posedge arst_n);
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("integer_to_ascii_converter verification failed");
		$finish;
	end

	initial begin
		func_t f;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: zero, all ones, sign boundaries, digit-count boundaries
		tx_calm = 1'b1;
		for (int i = 0; i < 4; i++) begin
			f = func_t'(i);
			queue_text(64'd0, f);
			queue_text(64'hffff_ffff_ffff_ffff, f);
			queue_text(64'h8000_0000_0000_0000, f);
		end
		tx_calm = 1'b0;
		queue_text(64'h7fff_ffff_ffff_ffff, FN_SDEC);
		queue_text(64'd1, FN_SDEC);
		queue_text(64'd9, FN_UDEC);
		queue_text(64'd10, FN_UDEC);
		queue_text(64'd9999999999999999999, FN_UDEC);
		queue_text(64'd10000000000000000000, FN_UDEC);
		queue_text(64'hf, FN_HEX);
		queue_text(64'h10, FN_HEX);
		queue_text(64'h0123_4567_89ab_cdef, FN_HEX);
		queue_text(64'hdead_beef, FN_PTR);
		queue_text(64'hfedc_ba98_7654_3210, FN_PTR);
		queue_text(64'hffff_ffff_ffff_fff6, FN_SDEC);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 40 == 0)
				tx_calm = ($urandom_range(0, 3) == 0);
			queue_text(pick_value(), func_t'($urandom_range(0, 3)));
		end

		while (requests.size() != 0 || s_tvalid || expected_chars.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		if (errors == 0)
			$display("integer_to_ascii_converter verification clean");
		else
			$display("integer_to_ascii_converter verification failed");
		$finish;
	end

endmodule

`default_nettype wire

### integer_to_ascii_converter.f
+incdir+rtl/core
rtl/core/i2a_pkg.sv
rtl/core/i2a_dabble.sv
rtl/core/integer_to_ascii_converter.sv
tb/sv/integer_to_ascii_converter_tb.sv
